// ----- rtl/fre_pkg.sv -----
package fre_pkg;

	localparam int STAMP_W    = 27;
	localparam int LVL_W      = 16;
	localparam int IVAL_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int X_W        = IVAL_W + 1;
	localparam int NUM_W      = GAIN_W + X_W;
	localparam int DEN_W      = IVAL_W + 1;
	localparam int QUOT_W     = DEN_W;
	localparam int DIV_STEPS  = QUOT_W;
	localparam int CNT_W      = $clog2(DIV_STEPS + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_IVAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_IVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_AS_OUT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_RANGE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MODE     = 3'd5;

	localparam logic KIND_PLAY = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [IVAL_W-1:0] IVAL_RESET = 16'd1000;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} fre_state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- rtl/fre_if.sv -----
interface fre_in_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic                       play_level;
	logic [fre_pkg::STAMP_W-1:0] now_ms;

	modport source (output valid, kind, play_level, now_ms, input ready);
	modport sink (input valid, kind, play_level, now_ms, output ready);
endinterface

interface fre_out_if;
	logic                      valid;
	logic                      ready;
	logic [fre_pkg::LVL_W-1:0] fade_in_level;
	logic [fre_pkg::LVL_W-1:0] fade_out_level;
	logic                      finished;

	modport source (output valid, fade_in_level, fade_out_level, finished, input ready);
	modport sink (input valid, fade_in_level, fade_out_level, finished, output ready);
endinterface

interface fre_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fre_pkg::CFG_IDX_W-1:0]  index;
	logic [fre_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/fre_div.sv -----
module fre_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fre_pkg::div_req_t req,
	output fre_pkg::div_rsp_t rsp
);
	import fre_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUOT_W-1:0] lo_q;
	logic [QUOT_W-1:0] quot_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;
	logic [DEN_W-1:0]  rem_next;

	always_comb begin
		trial    = {rem_q, lo_q[QUOT_W-1]};
		ge       = trial >= {1'b0, den_q};
		diff     = trial - {1'b0, den_q};
		rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {{(DEN_W - (NUM_W - QUOT_W)){1'b0}}, req.num[NUM_W-1:QUOT_W]};
			lo_q   <= req.num[QUOT_W-1:0];
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			lo_q   <= {lo_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ----- rtl/fade_ramp_envelope.sv -----
// Channel  Dir  Payload                                         Handshake
// cfg      in   index[2:0], data[15:0]                          valid/ready, ready always high
// item     in   kind, play_level, now_ms[26:0]                  valid/ready
// result   out  fade_in_level[15:0], fade_out_level[15:0], finished  valid/ready
//
// A play event or a tick while idle is handled without leaving the idle state.
// A running tick runs multiply, load, divide (one quotient bit a cycle) and output steps.
// The result sits in an output register; the next item is taken while it waits.
// A running tick stalls in its last step while the previous result is not yet taken.
// Reset sets the sequencer, ramp state, output and configuration registers to their reset values.
module fade_ramp_envelope (
	input  logic       clk,
	input  logic       arst_n,
	fre_cfg_if.sink    cfg,
	fre_in_if.sink     item,
	fre_out_if.source  result
);
	import fre_pkg::*;

	fre_state_t state_q;
	fre_state_t state_d;

	logic [IVAL_W-1:0]  fade_in_ival_q;
	logic [IVAL_W-1:0]  fade_out_ival_q;
	logic [GAIN_W-1:0]  gain_q;
	logic               in_as_out_q;
	logic               half_range_q;
	logic               hold_mode_q;

	logic               running_q;
	logic               fading_in_q;
	logic [IVAL_W-1:0]  elapsed_q;
	logic [STAMP_W-1:0] last_stamp_q;
	logic [IVAL_W-1:0]  ival_q;
	logic               fin_q;
	logic [NUM_W-1:0]   prod_q;
	logic [DEN_W-1:0]   den_q;
	logic [LVL_W-1:0]   held_in_q;
	logic [LVL_W-1:0]   held_out_q;
	logic               fin_out_q;
	logic               out_valid_q;

	logic               item_fire;
	logic               slot_free;
	logic               start_ramp;
	logic [STAMP_W-1:0] delta;
	logic [IVAL_W-1:0]  ival_sel;
	logic [STAMP_W:0]   sum;
	logic [IVAL_W-1:0]  elapsed_new;
	logic [X_W-1:0]     x_op;
	logic [DEN_W-1:0]   den_op;
	logic [LVL_W-1:0]   lvl;
	logic               load_out;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	fre_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == ST_IDLE);
	assign item_fire  = item.valid && item.ready;
	assign slot_free  = !out_valid_q || result.ready;

	always_comb begin
		delta = item.now_ms - last_stamp_q;
		if (delta[STAMP_W-1]) begin
			delta = '0;
		end
		ival_sel = fading_in_q ? fade_in_ival_q : fade_out_ival_q;
		if (ival_sel == '0) begin
			ival_sel = IVAL_W'(1);
		end
		sum = {{(STAMP_W + 1 - IVAL_W){1'b0}}, elapsed_q} + {1'b0, delta};
		elapsed_new = (sum > {{(STAMP_W + 1 - IVAL_W){1'b0}}, ival_sel}) ?
			ival_sel : sum[IVAL_W-1:0];
		start_ramp = hold_mode_q || item.play_level;
	end

	always_comb begin
		if (fading_in_q || !in_as_out_q) begin
			x_op   = {1'b0, elapsed_q};
			den_op = half_range_q ? {ival_q, 1'b0} : {1'b0, ival_q};
		end else if (half_range_q) begin
			x_op   = {1'b0, ival_q} + {1'b0, elapsed_q};
			den_op = {ival_q, 1'b0};
		end else begin
			x_op   = {1'b0, ival_q} - {1'b0, elapsed_q};
			den_op = {1'b0, ival_q};
		end
		lvl = div_rsp.quot[QUOT_W-1] ? {LVL_W{1'b1}} : div_rsp.quot[LVL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.num   = prod_q;
		div_req.den   = den_q;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_fire && item.kind == KIND_TICK && running_q) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_ival_q  <= IVAL_RESET;
			fade_out_ival_q <= IVAL_RESET;
			gain_q          <= GAIN_RESET;
			in_as_out_q     <= 1'b0;
			half_range_q    <= 1'b0;
			hold_mode_q     <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_FADE_IN_IVAL:  fade_in_ival_q  <= cfg.data[IVAL_W-1:0];
				CFG_FADE_OUT_IVAL: fade_out_ival_q <= cfg.data[IVAL_W-1:0];
				CFG_GAIN:          gain_q          <= cfg.data[GAIN_W-1:0];
				CFG_IN_AS_OUT:     in_as_out_q     <= cfg.data[0];
				CFG_HALF_RANGE:    half_range_q    <= cfg.data[0];
				CFG_HOLD_MODE:     hold_mode_q     <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			fading_in_q  <= 1'b1;
			elapsed_q    <= '0;
			last_stamp_q <= '0;
			held_in_q    <= '0;
			held_out_q   <= '0;
			fin_out_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (item_fire) begin
				if (item.kind == KIND_PLAY) begin
					if (start_ramp) begin
						fading_in_q  <= hold_mode_q ? item.play_level : !fading_in_q;
						elapsed_q    <= '0;
						last_stamp_q <= item.now_ms;
						running_q    <= 1'b1;
					end
				end else if (running_q) begin
					elapsed_q    <= elapsed_new;
					last_stamp_q <= item.now_ms;
					if (elapsed_new == ival_sel) begin
						running_q <= 1'b0;
					end
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				fin_out_q   <= fin_q;
				if (fading_in_q) begin
					held_in_q  <= lvl;
					held_out_q <= '0;
				end else if (in_as_out_q) begin
					held_in_q <= fin_q ? '0 : lvl;
				end else begin
					held_out_q <= fin_q ? '0 : lvl;
					held_in_q  <= '0;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire && item.kind == KIND_TICK && running_q) begin
			ival_q <= ival_sel;
			fin_q  <= (elapsed_new == ival_sel);
		end
		if (state_q == ST_MUL) begin
			prod_q <= gain_q * x_op;
			den_q  <= den_op;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.fade_in_level  = held_in_q;
	assign result.fade_out_level = held_out_q;
	assign result.finished       = fin_out_q;

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result became valid outside the output step");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished while the sequencer was not waiting");

	a_tick_starts_seq: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && item.kind == KIND_TICK && running_q |=> state_q == ST_MUL)
		else $error("running tick did not start the sequencer");

endmodule

// ----- tb/sv/fade_ramp_envelope_test.sv -----
module fade_ramp_envelope_test;
	import fre_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN = 40;
	localparam int CHOKE_LEN = 400;
	localparam int ITEM_GOAL = 1000;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	typedef struct packed {
		logic               kind;
		logic               play;
		logic [STAMP_W-1:0] now;
	} ramp_in_t;

	typedef struct packed {
		logic [LVL_W-1:0] in_lvl;
		logic [LVL_W-1:0] out_lvl;
		logic             done;
	} ramp_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_kind = KIND_PLAY;
	logic                  in_play = 1'b0;
	logic [STAMP_W-1:0]    in_now = '0;
	logic                  res_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_FADE_IN_IVAL;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fre_in_if  item_bus ();
	fre_out_if level_bus ();
	fre_cfg_if cfg_bus ();

	assign item_bus.valid = in_valid;
	assign item_bus.kind = in_kind;
	assign item_bus.play_level = in_play;
	assign item_bus.now_ms = in_now;
	assign level_bus.ready = res_ready;
	assign cfg_bus.valid = cfg_valid;
	assign cfg_bus.index = cfg_index;
	assign cfg_bus.data = cfg_data;

	fade_ramp_envelope dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.item   (item_bus),
		.result (level_bus)
	);

	// Shadow copy of the registers and the ramp.
	logic [IVAL_W-1:0] len_up = IVAL_RESET;
	logic [IVAL_W-1:0] len_down = IVAL_RESET;
	logic [GAIN_W-1:0] gain_q88 = GAIN_RESET;
	logic              mirror_out = 1'b0;
	logic              half_span = 1'b0;
	logic              follow_play = 1'b0;

	logic              ramp_up = 1'b1;
	logic              ramp_live = 1'b0;
	logic [IVAL_W-1:0] ramp_pos = '0;
	logic [STAMP_W-1:0] stamp_prev = '0;
	logic [LVL_W-1:0]  lvl_in_hold = '0;
	logic [LVL_W-1:0]  lvl_out_hold = '0;

	ramp_in_t  item_backlog[$];
	ramp_out_t due_levels[$];
	ramp_in_t  on_bus;
	ramp_out_t got_lvl;
	ramp_out_t want_lvl;

	logic [STAMP_W-1:0] stamp_gen = '0;
	logic calm = 1'b0;
	logic choke_req = 1'b0;
	logic choke = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;
	int moved = 0;
	int ignored = 0;
	int finishes = 0;
	int checked = 0;
	int errors = 0;
	int reg_writes = 0;
	int settings_seen = 0;
	int cycles = 0;

	always #4 clk = ~clk;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	function automatic logic [LVL_W-1:0] q88_ratio(input logic [47:0] num, input logic [47:0] den);
		logic [47:0] q;
		q = num / den;
		return (q > 48'hFFFF) ? 16'hFFFF : q[LVL_W-1:0];
	endfunction

	function automatic void advance_ramp(input ramp_in_t it);
		logic [STAMP_W-1:0] delta;
		logic [31:0] pos;
		logic [IVAL_W:0] span;
		logic [47:0] g, e, iv;
		logic [LVL_W-1:0] lin;
		logic fin;
		ramp_out_t lv;
		if (it.kind == KIND_PLAY) begin
			if (follow_play || it.play) begin
				ramp_up = follow_play ? it.play : !ramp_up;
				ramp_pos = '0;
				stamp_prev = it.now;
				ramp_live = 1'b1;
				moved++;
			end else begin
				ignored++;
			end
			return;
		end
		if (!ramp_live) begin
			ignored++;
			return;
		end
		moved++;
		delta = it.now - stamp_prev;
		if (delta[STAMP_W-1])
			delta = '0;
		span = {1'b0, (ramp_up ? len_up : len_down)};
		if (span == '0)
			span = (IVAL_W + 1)'(1);
		pos = 32'(ramp_pos) + 32'(delta);
		if (pos > 32'(span))
			pos = 32'(span);
		ramp_pos = pos[IVAL_W-1:0];
		fin = (pos == 32'(span));
		g = 48'(gain_q88);
		e = 48'(pos);
		iv = 48'(span);
		lin = q88_ratio(g * e, half_span ? (iv << 1) : iv);
		if (ramp_up) begin
			lvl_in_hold = lin;
			lvl_out_hold = '0;
		end else if (mirror_out) begin
			if (fin)
				lvl_in_hold = '0;
			else if (half_span)
				lvl_in_hold = q88_ratio(g * (iv + e), iv << 1);
			else
				lvl_in_hold = q88_ratio(g * (iv - e), iv);
		end else begin
			lvl_out_hold = fin ? '0 : lin;
			lvl_in_hold = '0;
		end
		if (fin) begin
			ramp_live = 1'b0;
			finishes++;
		end
		stamp_prev = it.now;
		lv.in_lvl = lvl_in_hold;
		lv.out_lvl = lvl_out_hold;
		lv.done = fin;
		due_levels.push_back(lv);
	endfunction

	function automatic int idle_len();
		int r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (in_valid && item_bus.ready)
				advance_ramp(on_bus);
			if (!in_valid || item_bus.ready) begin
				if (send_wait > 0 || item_backlog.size() == 0) begin
					if (send_wait > 0)
						send_wait--;
					in_valid <= 1'b0;
				end else begin
					on_bus = item_backlog.pop_front();
					in_valid <= 1'b1;
					in_kind <= on_bus.kind;
					in_play <= on_bus.play;
					in_now <= on_bus.now;
					send_wait = idle_len();
				end
			end
		end
	end

	function automatic void check_field(input string what, input logic [LVL_W-1:0] got,
			input logic [LVL_W-1:0] want);
		if (got !== want)
			flag_error($sformatf("%s mismatch on result %0d: expected %h, got %h",
				what, checked, want, got));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (level_bus.valid && res_ready) begin
				got_lvl.in_lvl = level_bus.fade_in_level;
				got_lvl.out_lvl = level_bus.fade_out_level;
				got_lvl.done = level_bus.finished;
				if (due_levels.size() == 0) begin
					flag_error($sformatf("Unexpected result: in %h out %h finished %b",
						got_lvl.in_lvl, got_lvl.out_lvl, got_lvl.done));
				end else begin
					want_lvl = due_levels.pop_front();
					checked++;
					check_field("fade_in_level", got_lvl.in_lvl, want_lvl.in_lvl);
					check_field("fade_out_level", got_lvl.out_lvl, want_lvl.out_lvl);
					check_field("finished", LVL_W'(got_lvl.done), LVL_W'(want_lvl.done));
				end
			end
			if (recv_wait > 0) begin
				recv_wait--;
				res_ready <= 1'b0;
			end else if (choke) begin
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				recv_wait = idle_len();
			end
		end
	end

	// Receiver hold-off long enough to back the block up into its input.
	initial begin
		wait (choke_req);
		@(posedge clk);
		choke <= 1'b1;
		repeat (CHOKE_LEN) @(posedge clk);
		choke <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycles, due_levels.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void queue_item(input logic k, input logic p, input logic [STAMP_W-1:0] t);
		ramp_in_t it;
		it.kind = k;
		it.play = p;
		it.now = t;
		item_backlog.push_back(it);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FADE_IN_IVAL:  len_up = val;
			CFG_FADE_OUT_IVAL: len_down = val;
			CFG_GAIN:          gain_q88 = val;
			CFG_IN_AS_OUT:     mirror_out = val[0];
			CFG_HALF_RANGE:    half_span = val[0];
			CFG_HOLD_MODE:     follow_play = val[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_mode(input logic [15:0] up, input logic [15:0] down, input logic [15:0] g,
			input logic mirror, input logic half, input logic follow);
		write_reg(CFG_FADE_IN_IVAL, up);
		write_reg(CFG_FADE_OUT_IVAL, down);
		write_reg(CFG_GAIN, g);
		write_reg(CFG_IN_AS_OUT, CFG_DATA_W'(mirror));
		write_reg(CFG_HALF_RANGE, CFG_DATA_W'(half));
		write_reg(CFG_HOLD_MODE, CFG_DATA_W'(follow));
		settings_seen++;
	endtask

	// Waits until every transfer is done and checked, then lets the block go quiet.
	task automatic settle();
		@(negedge clk);
		while (item_backlog.size() != 0 || in_valid || due_levels.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_len();
		int r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'hFFFF;
		if (r == 2)
			return 16'($urandom_range(1, 65535));
		return 16'($urandom_range(1, 200));
	endfunction

	function automatic logic [15:0] pick_gain();
		int r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic random_burst(input int n);
		int r;
		int reach;
		reach = int'(len_up > len_down ? len_up : len_down) / 3 + 1;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					STAMP_W'($urandom));
			end else if (r < 20) begin
				queue_item(KIND_PLAY, $urandom_range(0, 3) != 0, stamp_gen);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 6)
					stamp_gen = stamp_gen - STAMP_W'($urandom_range(1, 500));
				else if (r < 9)
					stamp_gen = stamp_gen + STAMP_W'($urandom_range(1, (1 << 26) - 1));
				else
					stamp_gen = stamp_gen + STAMP_W'($urandom_range(0, reach));
				queue_item(KIND_TICK, 1'($urandom_range(0, 1)), stamp_gen);
			end
		end
	endtask

	initial begin
		wait (arst_n === 1'b1);

		// Toggle mode at the reset settings: the first rising play turns the ramp into a fade-out.
		queue_item(KIND_TICK, 1'b0, 27'd5);
		queue_item(KIND_PLAY, 1'b0, 27'd10);
		queue_item(KIND_TICK, 1'b0, 27'd20);
		queue_item(KIND_PLAY, 1'b1, 27'd100);
		queue_item(KIND_TICK, 1'b0, 27'd600);
		queue_item(KIND_TICK, 1'b0, 27'd50);
		queue_item(KIND_TICK, 1'b0, 27'd2000);
		queue_item(KIND_TICK, 1'b0, 27'd2100);
		queue_item(KIND_PLAY, 1'b1, STAMP_MAX - STAMP_W'(27));
		queue_item(KIND_TICK, 1'b1, STAMP_MAX);
		queue_item(KIND_TICK, 1'b0, 27'd300);
		queue_item(KIND_TICK, 1'b0, 27'd3000);
		settle();

		// Hold mode, full-scale gain, shortest and longest intervals, fade-out mirrored.
		set_mode(16'hFFFF, 16'd1, 16'hFFFF, 1'b1, 1'b0, 1'b1);
		queue_item(KIND_PLAY, 1'b0, 27'd0);
		queue_item(KIND_TICK, 1'b0, 27'd0);
		queue_item(KIND_TICK, 1'b0, 27'd1);
		queue_item(KIND_PLAY, 1'b1, 27'd10);
		queue_item(KIND_TICK, 1'b0, 27'd40000);
		queue_item(KIND_TICK, 1'b0, 27'h3FF_FFFF);
		settle();

		// Zero interval and half range, mirrored fade-out.
		set_mode(16'd0, 16'd3, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		queue_item(KIND_PLAY, 1'b1, 27'd7);
		queue_item(KIND_TICK, 1'b0, 27'd7);
		queue_item(KIND_TICK, 1'b0, 27'd8);
		queue_item(KIND_PLAY, 1'b0, 27'd20);
		queue_item(KIND_TICK, 1'b0, 27'd21);
		queue_item(KIND_TICK, 1'b0, 27'd40);
		settle();

		// Long ramp offered back to back while the receiver holds off.
		set_mode(16'd60000, 16'd60000, 16'($urandom), 1'b0, 1'b0, 1'b1);
		calm = 1'b1;
		choke_req = 1'b1;
		stamp_gen = STAMP_W'($urandom);
		queue_item(KIND_PLAY, 1'b1, stamp_gen);
		for (int i = 0; i < 40; i++) begin
			stamp_gen = stamp_gen + STAMP_W'($urandom_range(1, 50));
			queue_item(KIND_TICK, 1'b0, stamp_gen);
		end
		settle();

		while (moved + ignored < ITEM_GOAL) begin
			set_mode(pick_len(), pick_len(), pick_gain(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				stamp_gen = STAMP_MAX - STAMP_W'($urandom_range(0, 3000));
			else
				stamp_gen = STAMP_W'($urandom);
			random_burst($urandom_range(40, 150));
			settle();
		end
		calm = 1'b0;

		$display("Covered %0d ramp-moving items and %0d ignored ones;", moved, ignored);
		$display("%0d results checked, %0d ramps finished, %0d register settings (%0d writes).",
			checked, finishes, settings_seen, reg_writes);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/fre_pkg.sv
rtl/fre_if.sv
rtl/fre_div.sv
rtl/fade_ramp_envelope.sv
tb/sv/fade_ramp_envelope_test.sv
